// File: src/ssae_pkg.sv
// sorted set algebra engine: shared constants, codes, types and the selector table
// no dependencies; imported by every module of the engine except ssae_ram
`timescale 1ns / 1ps

package ssae_pkg;

    // storage sizing
    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic        [CNT_W-1:0]  t_cnt;
    typedef logic signed [DATA_W-1:0] t_word;

    // request codes
    typedef enum logic [1:0] {
        OP_INS_A = 2'd0,
        OP_INS_B = 2'd1,
        OP_LIST  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_FULL    = 2'd2,
        ST_CLEARED = 2'd3
    } t_status;

    // list selector codes
    localparam logic [2:0] SEL_A         = 3'd0;
    localparam logic [2:0] SEL_B         = 3'd1;
    localparam logic [2:0] SEL_UNION     = 3'd2;
    localparam logic [2:0] SEL_INTER     = 3'd3;
    localparam logic [2:0] SEL_A_MINUS_B = 3'd4;
    localparam logic [2:0] SEL_B_MINUS_A = 3'd5;

    // merge step kinds, one bit each
    typedef logic [2:0] t_mask;
    localparam t_mask MASK_ONLY_A = 3'b001;
    localparam t_mask MASK_ONLY_B = 3'b010;
    localparam t_mask MASK_BOTH   = 3'b100;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_LIST,
        S_LIST_END,
        S_RESP
    } t_state;

    // one result beat handed to the output stage
    typedef struct packed {
        logic    vld;
        t_word   element;
        logic    empty_res;
        t_status status;
        logic    last;
    } t_item;

    // which merge kinds a selector keeps
    function automatic t_mask select_mask(input logic [2:0] sel);
        t_mask m;
        case (sel)
            SEL_A:         m = MASK_ONLY_A | MASK_BOTH;
            SEL_B:         m = MASK_ONLY_B | MASK_BOTH;
            SEL_UNION:     m = MASK_ONLY_A | MASK_ONLY_B | MASK_BOTH;
            SEL_INTER:     m = MASK_BOTH;
            SEL_A_MINUS_B: m = MASK_ONLY_A;
            SEL_B_MINUS_A: m = MASK_ONLY_B;
            default:       m = '0;
        endcase
        return m;
    endfunction

endpackage

// File: src/ssae_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ssae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: src/ssae_ctrl.sv
// sequencer of the engine: set stores, counts, shared signed comparator,
// insert ripple and merge walk; depends on ssae_pkg and ssae_ram
`timescale 1ns / 1ps

module ssae_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ssae_pkg::t_op   i_op,
    input  ssae_pkg::t_word i_value,
    input  logic [2:0]      i_which,
    input  logic            i_slot_free,
    output logic            o_ready,
    output ssae_pkg::t_item o_emit
);
    import ssae_pkg::*;

    t_state  r_state, n_state;
    t_cnt    r_a_cnt, n_a_cnt;
    t_cnt    r_b_cnt, n_b_cnt;
    t_cnt    r_idx, n_idx;
    t_cnt    r_a_idx, n_a_idx;
    t_cnt    r_b_idx, n_b_idx;
    logic    r_ripple, n_ripple;
    logic    r_held_vld, n_held_vld;
    t_word   r_key, n_key;
    t_word   r_carry, n_carry;
    t_word   r_held, n_held;
    t_status r_status, n_status;
    t_mask   r_mask, n_mask;
    logic    r_sel_b, n_sel_b;

    // store ports
    logic              a_we, b_we, wr_en;
    logic [ADDR_W-1:0] wr_addr, a_raddr, b_raddr;
    t_word             wr_data, a_rdata, b_rdata;

    // shared compare and walk decode
    t_cnt  cur_cnt;
    t_word ins_rd, cmp_x, cmp_y, merge_elem;
    logic  ins_end, ins_full, cmp_lt, cmp_eq;
    logic  a_ok, b_ok, take_a, take_b, take_both, hit, list_done, list_stall;
    t_mask kind;

    ssae_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    ssae_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // shared signed comparator and merge step decode
    always_comb begin
        cur_cnt  = r_sel_b ? r_b_cnt : r_a_cnt;
        ins_rd   = r_sel_b ? b_rdata : a_rdata;
        ins_end  = (r_idx == cur_cnt);
        ins_full = (cur_cnt == CNT_W'(CAPACITY));

        cmp_x  = (r_state == S_LIST) ? a_rdata : ins_rd;
        cmp_y  = (r_state == S_LIST) ? b_rdata : r_key;
        cmp_lt = (cmp_x < cmp_y);
        cmp_eq = (cmp_x == cmp_y);

        a_ok       = (r_a_idx < r_a_cnt);
        b_ok       = (r_b_idx < r_b_cnt);
        take_a     = a_ok && (!b_ok || cmp_lt);
        take_both  = a_ok && b_ok && cmp_eq;
        take_b     = b_ok && !take_a && !take_both;
        kind       = (take_a ? MASK_ONLY_A : '0) | (take_b ? MASK_ONLY_B : '0)
                   | (take_both ? MASK_BOTH : '0);
        hit        = |(kind & r_mask);
        merge_elem = take_b ? b_rdata : a_rdata;
        list_done  = !a_ok && !b_ok;
        list_stall = hit && r_held_vld && !i_slot_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_op)
                        OP_INS_A, OP_INS_B: n_state = S_INSERT;
                        OP_LIST:            n_state = S_LIST;
                        OP_CLEAR:           n_state = S_RESP;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_INSERT: begin
                if (ins_end || (!r_ripple && !cmp_lt && (cmp_eq || ins_full))) begin
                    n_state = S_RESP;
                end
            end
            S_LIST: begin
                if (list_done) begin
                    n_state = S_LIST_END;
                end
            end
            S_LIST_END, S_RESP: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_a_cnt    = r_a_cnt;
        n_b_cnt    = r_b_cnt;
        n_idx      = '0;
        n_a_idx    = '0;
        n_b_idx    = '0;
        n_ripple   = r_ripple;
        n_held_vld = r_held_vld;
        n_key      = r_key;
        n_carry    = r_carry;
        n_held     = r_held;
        n_status   = r_status;
        n_mask     = r_mask;
        n_sel_b    = r_sel_b;
        wr_en      = 1'b0;
        wr_data    = r_key;
        o_emit     = '0;
        o_ready    = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key      = i_value;
                    n_sel_b    = (i_op == OP_INS_B);
                    n_mask     = select_mask(i_which);
                    n_ripple   = 1'b0;
                    n_held_vld = 1'b0;
                    if (i_op == OP_CLEAR) begin
                        n_a_cnt  = '0;
                        n_b_cnt  = '0;
                        n_status = ST_CLEARED;
                    end
                end
            end
            // one stored element per cycle: search, then ripple the tail up by one
            S_INSERT: begin
                if (ins_end) begin
                    if (!r_ripple && ins_full) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        wr_data  = r_ripple ? r_carry : r_key;
                        n_status = ST_OK;
                        if (r_sel_b) begin
                            n_b_cnt = t_cnt'(r_b_cnt + 1'b1);
                        end else begin
                            n_a_cnt = t_cnt'(r_a_cnt + 1'b1);
                        end
                    end
                end else if (!r_ripple) begin
                    if (cmp_lt) begin
                        n_idx = t_cnt'(r_idx + 1'b1);
                    end else if (cmp_eq) begin
                        n_status = ST_DUP;
                    end else if (ins_full) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        wr_data  = r_key;
                        n_carry  = ins_rd;
                        n_ripple = 1'b1;
                        n_idx    = t_cnt'(r_idx + 1'b1);
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_data = r_carry;
                    n_carry = ins_rd;
                    n_idx   = t_cnt'(r_idx + 1'b1);
                end
            end
            // merge walk; a kept element waits in the held slot until the next
            // one shows that it is not the last
            S_LIST: begin
                n_a_idx = r_a_idx;
                n_b_idx = r_b_idx;
                if (!list_done && !list_stall) begin
                    if (take_a || take_both) begin
                        n_a_idx = t_cnt'(r_a_idx + 1'b1);
                    end
                    if (take_b || take_both) begin
                        n_b_idx = t_cnt'(r_b_idx + 1'b1);
                    end
                    if (hit) begin
                        n_held     = merge_elem;
                        n_held_vld = 1'b1;
                        if (r_held_vld) begin
                            o_emit.vld     = 1'b1;
                            o_emit.element = r_held;
                            o_emit.status  = ST_OK;
                        end
                    end
                end
            end
            S_LIST_END: begin
                if (i_slot_free) begin
                    o_emit.vld       = 1'b1;
                    o_emit.last      = 1'b1;
                    o_emit.status    = ST_OK;
                    o_emit.element   = r_held_vld ? r_held : '0;
                    o_emit.empty_res = !r_held_vld;
                end
            end
            S_RESP: begin
                if (i_slot_free) begin
                    o_emit.vld    = 1'b1;
                    o_emit.last   = 1'b1;
                    o_emit.status = r_status;
                end
            end
            default: o_emit = '0;
        endcase

        // store port steering
        a_we    = wr_en && !r_sel_b;
        b_we    = wr_en && r_sel_b;
        wr_addr = r_idx[ADDR_W-1:0];
        a_raddr = (r_state == S_INSERT && !r_sel_b) ? n_idx[ADDR_W-1:0]
                                                    : n_a_idx[ADDR_W-1:0];
        b_raddr = (r_state == S_INSERT && r_sel_b)  ? n_idx[ADDR_W-1:0]
                                                    : n_b_idx[ADDR_W-1:0];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_a_cnt    <= '0;
            r_b_cnt    <= '0;
            r_idx      <= '0;
            r_a_idx    <= '0;
            r_b_idx    <= '0;
            r_ripple   <= 1'b0;
            r_held_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_a_cnt    <= n_a_cnt;
            r_b_cnt    <= n_b_cnt;
            r_idx      <= n_idx;
            r_a_idx    <= n_a_idx;
            r_b_idx    <= n_b_idx;
            r_ripple   <= n_ripple;
            r_held_vld <= n_held_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_carry  <= n_carry;
        r_held   <= n_held;
        r_status <= n_status;
        r_mask   <= n_mask;
        r_sel_b  <= n_sel_b;
    end

endmodule

// File: src/ssae_out.sv
// output register stage: holds one result beat until the sink takes it
// depends on ssae_pkg
`timescale 1ns / 1ps

module ssae_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ssae_pkg::t_item       i_emit,
    output logic                  o_slot_free,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [31:0]           o_m_tdata,
    output logic [2:0]            o_m_tuser,
    output logic                  o_m_tlast
);
    import ssae_pkg::*;

    logic  r_valid;
    t_item r_item;

    // slot frees up in the same cycle the sink takes the beat
    assign o_slot_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit.vld) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.vld) begin
            r_item <= i_emit;
        end
    end

    // beat packing
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_item.element;
    assign o_m_tuser  = {r_item.status, r_item.empty_res};
    assign o_m_tlast  = r_item.last;

endmodule

// File: src/sorted_set_algebra_engine.sv
// top level of the sorted set algebra engine: stream ports, sequencer, output stage
// depends on ssae_pkg, ssae_ctrl, ssae_out
//
// channel   | direction | tdata           | tuser (low bit up)                 | tlast
// ----------+-----------+-----------------+------------------------------------+--------------
// s (req)   | in        | value [31:0]    | operation [1:0], which_set [4:2]   | -
// m (res)   | out       | element [31:0]  | empty_res [0], status [2:1]        | last of run
//
// insert: one stored element of the target set per cycle
// list: one merge step per cycle on the shared comparator, unless the output register stalls it
// clear: empties both sets; s_tready is high only between requests
// a full output register stalls the merge walk and the final beat; no clearing pass after reset
// reset is synchronous, active low, and empties both sets
`timescale 1ns / 1ps

module sorted_set_algebra_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // value
    input  logic [4:0]  i_s_tuser,   // operation [1:0], which_set [4:2]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // element
    output logic [2:0]  o_m_tuser,   // empty_res [0], status [2:1]
    output logic        o_m_tlast
);
    import ssae_pkg::*;

    logic  start;
    logic  slot_free;
    t_item emit;

    // request beat accepted
    assign start = i_s_tvalid && o_s_tready;

    ssae_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (t_op'(i_s_tuser[1:0])),
        .i_value     (i_s_tdata),
        .i_which     (i_s_tuser[4:2]),
        .i_slot_free (slot_free),
        .o_ready     (o_s_tready),
        .o_emit      (emit)
    );

    ssae_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (emit),
        .o_slot_free (slot_free),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// File: tb/sv/tb_sorted_set_algebra_engine.sv
// self-checking testbench for the sorted set algebra engine: predicts every result beat
// depends on ssae_pkg and sorted_set_algebra_engine
`timescale 1ns / 1ps

module tb_sorted_set_algebra_engine;
    import ssae_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    // one predicted result beat
    typedef struct {
        t_word   element;
        logic    empty_res;
        t_status status;
        logic    last;
    } t_set_beat;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;   // value
    logic [4:0]  i_s_tuser  = '0;   // operation [1:0], which_set [4:2]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;         // element
    logic [2:0]  o_m_tuser;         // empty_res [0], status [2:1]
    logic        o_m_tlast;

    t_set_beat expected_beats[$];
    t_word     members_a[$];
    t_word     members_b[$];

    int src_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    int err_count    = 0;
    int cycle_count  = 0;

    sorted_set_algebra_engine u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sorted_set_algebra_engine verification failed");
            $finish;
        end
    end

    // receiver: long hold-off when requested, otherwise random stalls
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // compare each accepted result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_set_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_beats.size() == 0) begin
                err_count++;
                $display("%0t: unexpected beat: expected none, actual element %0d tuser %b last %b",
                         $time, $signed(o_m_tdata), o_m_tuser, o_m_tlast);
            end else begin
                want = expected_beats.pop_front();
                if (o_m_tdata !== want.element) begin
                    err_count++;
                    $display("%0t: element mismatch: expected %0d, actual %0d",
                             $time, want.element, $signed(o_m_tdata));
                end
                if (o_m_tuser[0] !== want.empty_res) begin
                    err_count++;
                    $display("%0t: empty_res mismatch: expected %b, actual %b",
                             $time, want.empty_res, o_m_tuser[0]);
                end
                if (o_m_tuser[2:1] !== want.status) begin
                    err_count++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_m_tuser[2:1]);
                end
                if (o_m_tlast !== want.last) begin
                    err_count++;
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, o_m_tlast);
                end
            end
        end
    end

    // sorted insert into one member list, returns the status the block reports
    function automatic t_status add_member(ref t_word members[$], input t_word v);
        int pos;
        pos = 0;
        while (pos < members.size() && members[pos] < v)
            pos++;
        if (pos < members.size() && members[pos] == v)
            return ST_DUP;
        if (members.size() >= CAPACITY)
            return ST_FULL;
        members.insert(pos, v);
        return ST_OK;
    endfunction

    // whether a merged element belongs to the chosen set
    function automatic bit keeps_member(input logic [2:0] sel, input bit in_a, input bit in_b);
        case (sel)
            SEL_A:         return in_a;
            SEL_B:         return in_b;
            SEL_UNION:     return 1'b1;
            SEL_INTER:     return in_a && in_b;
            SEL_A_MINUS_B: return in_a && !in_b;
            SEL_B_MINUS_A: return in_b && !in_a;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic void push_beat(input t_word e, input logic emp, input t_status st,
                                      input logic lst);
        t_set_beat b;
        b.element   = e;
        b.empty_res = emp;
        b.status    = st;
        b.last      = lst;
        expected_beats.push_back(b);
    endfunction

    // predicted result beats of one accepted request
    function automatic void predict_set_op(input t_op op, input t_word val,
                                           input logic [2:0] sel);
        int      i;
        int      j;
        int      listed;
        t_word   v;
        bit      in_a;
        bit      in_b;
        t_status st;
        case (op)
            OP_INS_A: begin
                st = add_member(members_a, val);
                push_beat('0, 1'b0, st, 1'b1);
            end
            OP_INS_B: begin
                st = add_member(members_b, val);
                push_beat('0, 1'b0, st, 1'b1);
            end
            OP_LIST: begin
                i = 0;
                j = 0;
                listed = 0;
                // merge walk over both sorted lists
                while (i < members_a.size() || j < members_b.size()) begin
                    if (j >= members_b.size() ||
                        (i < members_a.size() && members_a[i] < members_b[j])) begin
                        v = members_a[i];
                        in_a = 1'b1;
                        in_b = 1'b0;
                        i++;
                    end else if (i >= members_a.size() || members_b[j] < members_a[i]) begin
                        v = members_b[j];
                        in_a = 1'b0;
                        in_b = 1'b1;
                        j++;
                    end else begin
                        v = members_a[i];
                        in_a = 1'b1;
                        in_b = 1'b1;
                        i++;
                        j++;
                    end
                    if (keeps_member(sel, in_a, in_b)) begin
                        push_beat(v, 1'b0, ST_OK, 1'b0);
                        listed++;
                    end
                end
                if (listed == 0)
                    push_beat('0, 1'b1, ST_OK, 1'b1);
                else
                    expected_beats[expected_beats.size() - 1].last = 1'b1;
            end
            default: begin
                members_a.delete();
                members_b.delete();
                push_beat('0, 1'b0, ST_CLEARED, 1'b1);
            end
        endcase
    endfunction

    // offer one request beat, wait for its handshake, then predict
    task automatic send_req(input t_op op, input t_word val, input logic [2:0] sel);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= val;
        i_s_tuser  <= {sel, op};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        predict_set_op(op, val, sel);
    endtask

    // values clustered so that sets overlap and repeat, plus extremes and wide values
    function automatic t_word pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return t_word'($urandom_range(48)) - 24;
        if (r < 70) begin
            case ($urandom_range(3))
                0:       return t_word'(32'h8000_0000);
                1:       return t_word'(32'h7fff_ffff);
                2:       return t_word'(32'h8000_0001);
                default: return t_word'(32'h7fff_fffe);
            endcase
        end
        return t_word'($urandom);
    endfunction

    // extremes of the value field and a duplicate
    task automatic test_insert_extremes();
        send_req(OP_INS_A, t_word'(32'h8000_0000), SEL_A);
        send_req(OP_INS_A, t_word'(32'h7fff_ffff), 3'd7);
        send_req(OP_INS_A, 0, SEL_B);
        send_req(OP_INS_A, -1, SEL_UNION);
        send_req(OP_INS_A, t_word'(32'h8000_0000), SEL_A);
        send_req(OP_INS_B, t_word'(32'h7fff_ffff), SEL_INTER);
        send_req(OP_INS_B, 1, SEL_A_MINUS_B);
        send_req(OP_INS_B, -1, SEL_B_MINUS_A);
        send_req(OP_INS_B, t_word'(32'h8000_0000), 3'd6);
    endtask

    // every selector, including the two with no meaning
    task automatic test_list_selectors();
        for (int s = 0; s < 8; s++)
            send_req(OP_LIST, t_word'($urandom), 3'(s));
    endtask

    // clear, then lists of empty sets
    task automatic test_clear_and_empty();
        send_req(OP_CLEAR, t_word'($urandom), 3'($urandom_range(7)));
        send_req(OP_LIST, 0, SEL_UNION);
        send_req(OP_INS_B, 7, SEL_A);
        send_req(OP_LIST, 0, SEL_A_MINUS_B);
    endtask

    // both sets up to capacity, duplicate and drop on a full set, every set listed
    task automatic test_fill_to_capacity();
        send_req(OP_CLEAR, 0, SEL_A);
        for (int k = 0; k < CAPACITY; k++)
            send_req(OP_INS_A, t_word'(((k * 7) % CAPACITY) * 2 - 31), 3'($urandom_range(7)));
        send_req(OP_INS_A, -31, SEL_A);
        send_req(OP_INS_A, t_word'(32'h7fff_ffff), SEL_A);
        send_req(OP_INS_A, t_word'(32'h8000_0000), SEL_A);
        for (int k = 0; k < CAPACITY; k++)
            send_req(OP_INS_B, t_word'(((k * 5) % CAPACITY) * 3 - 40), 3'($urandom_range(7)));
        send_req(OP_INS_B, 1000, SEL_B);
        for (int s = 0; s < 6; s++)
            send_req(OP_LIST, 0, 3'(s));
    endtask

    // receiver held off for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        src_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_left = 400;
        for (int k = 0; k < 20; k++) begin
            if (k % 3 == 0)
                send_req(OP_LIST, t_word'($urandom), 3'($urandom_range(5)));
            else
                send_req(OP_INS_B, pick_value(), 3'($urandom_range(7)));
        end
    endtask

    // mixed traffic under one idling setting
    task automatic test_random_traffic(input int src_pct, input int rx_pct, input int count);
        int r;
        src_idle_pct = src_pct;
        rx_stall_pct = rx_pct;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 36)
                send_req(OP_INS_A, pick_value(), 3'($urandom_range(7)));
            else if (r < 72)
                send_req(OP_INS_B, pick_value(), 3'($urandom_range(7)));
            else if (r < 97)
                send_req(OP_LIST, t_word'($urandom), 3'($urandom_range(7)));
            else
                send_req(OP_CLEAR, t_word'($urandom), 3'($urandom_range(7)));
        end
    endtask

    // sequence of tests, then drain and verdict
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_insert_extremes();
        test_list_selectors();
        test_clear_and_empty();
        test_fill_to_capacity();
        test_output_backpressure();
        test_random_traffic(0, 0, 48);
        test_random_traffic(46, 0, 48);
        test_random_traffic(0, 46, 48);
        test_random_traffic(29, 29, 48);

        i_s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (err_count == 0)
            $display("sorted_set_algebra_engine verification clean");
        else
            $display("sorted_set_algebra_engine verification failed");
        $finish;
    end

endmodule
